// ----- rtl/core/iee_pkg.sv -----
// ----------------------------------------------------------------------------
// iee_pkg
// Shared sizes, request codes, command/status bundles and saturating helpers
// for the Ising energy engine.
// ----------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

  // Array geometry and weight format
  localparam int NUM_SPINS   = 64;
  localparam int WEIGHT_BITS = 24;

  // Fixed field widths on the request and response channels
  localparam int TYPE_W   = 3;
  localparam int IDX_W    = 6;
  localparam int IN_W     = 24;
  localparam int ENERGY_W = 48;
  localparam int CFG_W    = 32;

  // Derived sizes
  localparam int SPIN_W    = (NUM_SPINS > 1) ? $clog2(NUM_SPINS) : 1;
  localparam int CPL_AW    = 2 * SPIN_W;
  localparam int CPL_DEPTH = 1 << CPL_AW;
  localparam int SUM_W     = ((WEIGHT_BITS > IN_W) ? WEIGHT_BITS : IN_W) + 1;
  localparam int ACC_RAW   = WEIGHT_BITS + 2 * SPIN_W + 4;
  localparam int ACC_W     = (ACC_RAW > ENERGY_W + 2) ? ACC_RAW : ENERGY_W + 2;

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_ADD_CPL     = TYPE_W'(0);
  localparam logic [TYPE_W-1:0] REQ_ADD_FIELD   = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] REQ_FLIP        = TYPE_W'(2);
  localparam logic [TYPE_W-1:0] REQ_QUERY_DELTA = TYPE_W'(3);
  localparam logic [TYPE_W-1:0] REQ_QUERY_TOTAL = TYPE_W'(4);

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_step;
    logic cpl_wr;
    logic swap;
    logic fld_wr;
    logic spn_wr;
    logic scan_step;
    logic result_load;
  } iee_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic out_free;
  } iee_stat_t;

  function automatic logic spin_ok(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(NUM_SPINS);
  endfunction

  // Add a request amount to a table entry, clamped to the weight range
  function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(
    input logic signed [WEIGHT_BITS-1:0] cur,
    input logic signed [IN_W-1:0]        amt
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    s  = SUM_W'(cur) + SUM_W'(amt);
    hi = {{(SUM_W-WEIGHT_BITS+1){1'b0}}, {(WEIGHT_BITS-1){1'b1}}};
    lo = ~hi;
    if (s > hi) begin
      s = hi;
    end else if (s < lo) begin
      s = lo;
    end
    return WEIGHT_BITS'(s);
  endfunction

  // Clamp an accumulator value to the energy output range
  function automatic logic signed [ENERGY_W-1:0] sat_energy(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] r;
    hi = {{(ACC_W-ENERGY_W+1){1'b0}}, {(ENERGY_W-1){1'b1}}};
    lo = ~hi;
    r  = v;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end
    return ENERGY_W'(r);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/iee_req_if.sv -----
// ----------------------------------------------------------------------------
// iee_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface iee_req_if;
  logic                             valid;
  logic                             ready;
  logic [iee_pkg::TYPE_W-1:0]       req_type;
  logic [iee_pkg::IDX_W-1:0]        spin_a;
  logic [iee_pkg::IDX_W-1:0]        spin_b;
  logic signed [iee_pkg::IN_W-1:0]  weight_value;

  modport source (output valid, req_type, spin_a, spin_b, weight_value, input ready);
  modport sink   (input valid, req_type, spin_a, spin_b, weight_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/iee_rsp_if.sv -----
// ----------------------------------------------------------------------------
// iee_rsp_if
// Response channel: valid/ready handshake with the energy answer.
// ----------------------------------------------------------------------------
`default_nettype none

interface iee_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [iee_pkg::ENERGY_W-1:0] energy_value;
  logic                                is_total;

  modport source (output valid, energy_value, is_total, input ready);
  modport sink   (input valid, energy_value, is_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/iee_ctrl.sv -----
// ----------------------------------------------------------------------------
// iee_ctrl
// Request sequencer: clearing pass, read-modify-write sequences and the
// coupling scan, driving the datapath through one command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [iee_pkg::TYPE_W-1:0] req_type,
  input  iee_pkg::iee_stat_t         stat,
  output iee_pkg::iee_cmd_t          cmd,
  output logic                       in_ready
);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'h0001,
    S_IDLE     = 13'h0002,
    S_CPL_RD   = 13'h0004,
    S_CPL_WR   = 13'h0008,
    S_CPL_RD2  = 13'h0010,
    S_CPL_WR2  = 13'h0020,
    S_FLD_RD   = 13'h0040,
    S_FLD_WR   = 13'h0080,
    S_SPN_RD   = 13'h0100,
    S_SPN_WR   = 13'h0200,
    S_SCAN     = 13'h0400,
    S_DRAIN    = 13'h0800,
    S_DONE     = 13'h1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = accept;
        if (accept) begin
          case (req_type)
            iee_pkg::REQ_ADD_CPL:     state_next = S_CPL_RD;
            iee_pkg::REQ_ADD_FIELD:   state_next = S_FLD_RD;
            iee_pkg::REQ_FLIP:        state_next = S_SPN_RD;
            iee_pkg::REQ_QUERY_DELTA,
            iee_pkg::REQ_QUERY_TOTAL: state_next = S_SCAN;
            default:                  state_next = S_IDLE;
          endcase
        end
      end
      S_CPL_RD:  state_next = S_CPL_WR;
      S_CPL_WR: begin
        cmd.cpl_wr = 1'b1;
        state_next = S_CPL_RD2;
      end
      S_CPL_RD2: begin
        cmd.swap   = 1'b1;
        state_next = S_CPL_WR2;
      end
      S_CPL_WR2: begin
        cmd.swap   = 1'b1;
        cmd.cpl_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_FLD_RD:  state_next = S_FLD_WR;
      S_FLD_WR: begin
        cmd.fld_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_SPN_RD:  state_next = S_SPN_WR;
      S_SPN_WR: begin
        cmd.spn_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      // let the last term land in the accumulator
      S_DRAIN:   state_next = S_DONE;
      S_DONE: begin
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default:   state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/iee_datapath.sv -----
// ----------------------------------------------------------------------------
// iee_datapath
// Coupling, field and spin memories, scan counters, energy accumulator,
// offset register and the response output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  iee_pkg::iee_cmd_t                   cmd,
  output iee_pkg::iee_stat_t                  stat,
  input  logic [iee_pkg::TYPE_W-1:0]          req_type,
  input  logic [iee_pkg::IDX_W-1:0]           spin_a,
  input  logic [iee_pkg::IDX_W-1:0]           spin_b,
  input  logic signed [iee_pkg::IN_W-1:0]     weight_value,
  input  logic                                cfg_wr_en,
  input  logic [iee_pkg::CFG_W-1:0]           cfg_wr_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [iee_pkg::ENERGY_W-1:0] energy_value,
  output logic                                is_total
);

  localparam int W     = iee_pkg::WEIGHT_BITS;
  localparam int SW    = iee_pkg::SPIN_W;
  localparam int AW    = iee_pkg::CPL_AW;
  localparam int ACC_W = iee_pkg::ACC_W;
  localparam int N     = iee_pkg::NUM_SPINS;
  localparam logic [SW-1:0] LAST_IDX = SW'(N - 1);

  // Request context
  logic [SW-1:0]                    row;
  logic [SW-1:0]                    col;
  logic                             is_tot;
  logic                             a_ok;
  logic                             b_ok;
  logic signed [iee_pkg::IN_W-1:0]  weight;
  logic signed [iee_pkg::CFG_W-1:0] energy_offset;

  // Clearing pass
  logic [AW-1:0] clr_addr;

  // Coupling memory
  logic signed [W-1:0] cpl_mem [iee_pkg::CPL_DEPTH];
  logic signed [W-1:0] cpl_rdata;
  logic signed [W-1:0] cpl_wdata;
  logic [AW-1:0]       cpl_addr;
  logic                cpl_we;

  // Field memory with per-entry valid bits
  logic signed [W-1:0] fld_mem [N];
  logic [N-1:0]        fld_vld;
  logic signed [W-1:0] fld_rdata;
  logic                fld_rvld;
  logic signed [W-1:0] fld_val;
  logic                fld_we;

  // Spin memory (1 = down) with per-entry valid bits, reads at row and col
  logic         spn_mem [N];
  logic [N-1:0] spn_vld;
  logic         spn_rdata0;
  logic         spn_rvld0;
  logic         spn_rdata1;
  logic         spn_rvld1;
  logic         spn_eff0;
  logic         spn_eff1;
  logic         spn_we;

  // Scan pipeline and accumulator
  logic                    term_vld;
  logic                    term_first;
  logic                    term_skip;
  logic                    sign_a;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] j_ext;
  logic signed [ACC_W-1:0] h_ext;
  logic signed [ACC_W-1:0] j_term;
  logic signed [ACC_W-1:0] h_term;
  logic signed [ACC_W-1:0] dbl;
  logic signed [ACC_W-1:0] res;
  logic                    j_neg;
  logic                    in_total;
  logic                    in_query;

  assign in_total = (req_type == iee_pkg::REQ_QUERY_TOTAL);
  assign in_query = (req_type == iee_pkg::REQ_QUERY_DELTA) || in_total;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_offset <= '0;
    end else if (cfg_wr_en) begin
      energy_offset <= cfg_wr_data;
    end
  end

  // Latch the request and set up the scan position
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_tot <= in_total;
      a_ok   <= iee_pkg::spin_ok(spin_a);
      b_ok   <= iee_pkg::spin_ok(spin_b);
      weight <= weight_value;
      row    <= in_total ? '0 : SW'(spin_a);
      col    <= in_query ? '0 : SW'(spin_b);
    end else if (cmd.scan_step) begin
      // total walks the lower triangle, delta walks one row
      if (is_tot && (col == row)) begin
        col <= '0;
        row <= row + SW'(1);
      end else begin
        col <= col + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Coupling memory: one read and one write port
  assign cpl_addr  = cmd.clr_step ? clr_addr : (cmd.swap ? {col, row} : {row, col});
  assign cpl_we    = cmd.clr_step
                   | (cmd.cpl_wr & a_ok & b_ok & ~(cmd.swap & (row == col)));
  assign cpl_wdata = cmd.clr_step ? '0 : iee_pkg::sat_weight(cpl_rdata, weight);

  always_ff @(posedge clk) begin
    if (cpl_we) begin
      cpl_mem[cpl_addr] <= cpl_wdata;
    end
    cpl_rdata <= cpl_mem[cpl_addr];
  end

  // Field memory
  assign fld_val = fld_rvld ? fld_rdata : '0;
  assign fld_we  = cmd.fld_wr & a_ok;

  always_ff @(posedge clk) begin
    if (fld_we) begin
      fld_mem[row] <= iee_pkg::sat_weight(fld_val, weight);
    end
    fld_rdata <= fld_mem[row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fld_vld  <= '0;
      fld_rvld <= 1'b0;
    end else begin
      if (fld_we) begin
        fld_vld[row] <= 1'b1;
      end
      fld_rvld <= fld_vld[row];
    end
  end

  // Spin memory
  assign spn_eff0 = spn_rvld0 & spn_rdata0;
  assign spn_eff1 = spn_rvld1 & spn_rdata1;
  assign spn_we   = cmd.spn_wr & a_ok;

  always_ff @(posedge clk) begin
    if (spn_we) begin
      spn_mem[row] <= ~spn_eff0;
    end
    spn_rdata0 <= spn_mem[row];
    spn_rdata1 <= spn_mem[col];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spn_vld   <= '0;
      spn_rvld0 <= 1'b0;
      spn_rvld1 <= 1'b0;
    end else begin
      if (spn_we) begin
        spn_vld[row] <= 1'b1;
      end
      spn_rvld0 <= spn_vld[row];
      spn_rvld1 <= spn_vld[col];
    end
  end

  // Scan term: the read issued last cycle lands now
  always_ff @(posedge clk) begin
    if (rst) begin
      term_vld <= 1'b0;
    end else begin
      term_vld <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    term_first <= (col == '0);
    term_skip  <= ~is_tot & (col == row);
  end

  assign j_ext  = {{(ACC_W-W){cpl_rdata[W-1]}}, cpl_rdata};
  assign h_ext  = {{(ACC_W-W){fld_val[W-1]}}, fld_val};
  assign j_neg  = is_tot ? (spn_eff0 ^ spn_eff1) : spn_eff1;
  assign j_term = term_skip ? '0 : (j_neg ? -j_ext : j_ext);
  assign h_term = ~term_first ? '0 : ((is_tot & spn_eff0) ? -h_ext : h_ext);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= in_total ? {{(ACC_W-iee_pkg::CFG_W){energy_offset[iee_pkg::CFG_W-1]}},
                         energy_offset}
                      : '0;
    end else if (term_vld) begin
      acc    <= acc + j_term + h_term;
      sign_a <= spn_eff0;
    end
  end

  // Delta is -2 * s_a * local field
  assign dbl = acc <<< 1;
  assign res = is_tot ? acc : (a_ok ? (sign_a ? dbl : -dbl) : '0);

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      energy_value <= iee_pkg::sat_energy(res);
      is_total     <= is_tot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.clr_last  = (clr_addr == '1);
  assign stat.scan_last = is_tot ? ((row == LAST_IDX) && (col == row)) : (col == LAST_IDX);
  assign stat.out_free  = ~out_valid | out_ready;

endmodule

`default_nettype wire

// ----- rtl/core/ising_energy_engine.sv -----
// ----------------------------------------------------------------------------
// ising_energy_engine
// Ising spin array with coupling and field tables; answers flip-delta and
// total-energy queries.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req       in   valid/ready    req_type, spin_a, spin_b, weight_value
//  rsp       out  valid/ready    energy_value, is_total
//  cfg       in   cfg_wr_en      cfg_wr_data (energy_offset)
//
//  Counting from one accepted request to the next, add coupling runs accept,
//  read and write of the entry, then read and write of the mirrored entry;
//  add field and flip run accept, memory read, write. A delta query walks
//  one coupling row. A total query walks the lower triangle of the coupling
//  memory, one entry a cycle: NUM_SPINS*(NUM_SPINS+1)/2 entries. After reset
//  a clearing pass writes zero over all 2**(2*SPIN_W) (4096) coupling entries,
//  with req.ready low. A result waiting in the output register does not stall
//  writes or flips; a query stalls in its last state until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_energy_engine (
  input  logic                       clk,
  input  logic                       rst,
  iee_req_if.sink                    req,
  iee_rsp_if.source                  rsp,
  input  logic                       cfg_wr_en,
  input  logic [iee_pkg::CFG_W-1:0]  cfg_wr_data
);

  iee_pkg::iee_cmd_t  cmd;
  iee_pkg::iee_stat_t stat;
  logic               accept;
  logic               in_ready;

  assign req.ready = in_ready;
  assign accept    = req.valid & in_ready;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (req.req_type),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  iee_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req.req_type),
    .spin_a       (req.spin_a),
    .spin_b       (req.spin_b),
    .weight_value (req.weight_value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .energy_value (rsp.energy_value),
    .is_total     (rsp.is_total)
  );

  // No request is taken while the coupling memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !req.ready)
    else $error("request channel open during clearing pass");

  // A result is only loaded when the output register can take it
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> (!rsp.valid || rsp.ready))
    else $error("result overwrote a pending response");

  // A query holds off further requests while it scans
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.req_type == iee_pkg::REQ_QUERY_DELTA ||
                req.req_type == iee_pkg::REQ_QUERY_TOTAL)) |=> !req.ready)
    else $error("request accepted during a scan");

  // Every loaded result shows up on the response channel next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> rsp.valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- verif/iee_energy_checker.sv -----
// ----------------------------------------------------------------------------
// iee_energy_checker
// Watches the request, response and offset ports of the Ising energy engine,
// keeps its own copy of the spins, couplings, fields and offset, predicts
// each delta and total energy answer, and compares every answer taken
// against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iee_energy_checker
  import iee_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  iee_req_if               req,
  iee_rsp_if               rsp,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output int               mismatch_count,
  output int               outstanding
);

  typedef struct {
    logic signed [ENERGY_W-1:0] energy;
    logic                       is_total;
  } energy_answer_t;

  logic signed [WEIGHT_BITS-1:0] coupling_w [NUM_SPINS][NUM_SPINS];
  logic signed [WEIGHT_BITS-1:0] field_w [NUM_SPINS];
  bit                            spin_down [NUM_SPINS];
  logic signed [CFG_W-1:0]       offset_q8;
  energy_answer_t                energy_answers_q [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  function automatic logic signed [WEIGHT_BITS-1:0] clamp_weight(
    input logic signed [WEIGHT_BITS-1:0] cur,
    input logic signed [IN_W-1:0]        amt
  );
    longint s;
    longint w_top;
    w_top = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
    s     = longint'(cur) + longint'(amt);
    if (s > w_top) begin
      s = w_top;
    end else if (s < -w_top - 1) begin
      s = -w_top - 1;
    end
    return WEIGHT_BITS'(s);
  endfunction

  function automatic logic signed [ENERGY_W-1:0] clamp_energy(input longint e);
    longint e_top;
    e_top = (longint'(1) <<< (ENERGY_W - 1)) - 1;
    if (e > e_top) begin
      e = e_top;
    end else if (e < -e_top - 1) begin
      e = -e_top - 1;
    end
    return ENERGY_W'(e);
  endfunction

  function automatic longint by_spin(input longint v, input bit down);
    return down ? -v : v;
  endfunction

  // Self coupling is left out: flipping spin a does not change J[a][a]
  function automatic logic signed [ENERGY_W-1:0] predict_delta(input int a);
    longint acc;
    acc = longint'(field_w[a]);
    for (int j = 0; j < NUM_SPINS; j++) begin
      if (j != a) begin
        acc += by_spin(longint'(coupling_w[a][j]), spin_down[j]);
      end
    end
    return clamp_energy(-2 * by_spin(acc, spin_down[a]));
  endfunction

  // Lower triangle only, so each edge and each self coupling counts once
  function automatic logic signed [ENERGY_W-1:0] predict_total();
    longint sum;
    longint row;
    sum = longint'(offset_q8);
    for (int i = 0; i < NUM_SPINS; i++) begin
      row = 0;
      for (int j = 0; j <= i; j++) begin
        row += by_spin(longint'(coupling_w[i][j]), spin_down[j]);
      end
      sum += by_spin(row, spin_down[i]);
      sum += by_spin(longint'(field_w[i]), spin_down[i]);
    end
    return clamp_energy(sum);
  endfunction

  function automatic void apply_request(
    input logic [TYPE_W-1:0]      kind,
    input logic [IDX_W-1:0]       a,
    input logic [IDX_W-1:0]       b,
    input logic signed [IN_W-1:0] w
  );
    energy_answer_t ans;
    case (kind)
      REQ_ADD_CPL: begin
        if (spin_ok(a) && spin_ok(b)) begin
          coupling_w[a][b] = clamp_weight(coupling_w[a][b], w);
          if (a != b) begin
            coupling_w[b][a] = clamp_weight(coupling_w[b][a], w);
          end
        end
      end
      REQ_ADD_FIELD: begin
        if (spin_ok(a)) begin
          field_w[a] = clamp_weight(field_w[a], w);
        end
      end
      REQ_FLIP: begin
        if (spin_ok(a)) begin
          spin_down[a] = !spin_down[a];
        end
      end
      REQ_QUERY_DELTA: begin
        ans.energy   = spin_ok(a) ? predict_delta(int'(a)) : '0;
        ans.is_total = 1'b0;
        energy_answers_q.insert(energy_answers_q.size(), ans);
      end
      REQ_QUERY_TOTAL: begin
        ans.energy   = predict_total();
        ans.is_total = 1'b1;
        energy_answers_q.insert(energy_answers_q.size(), ans);
      end
      default: begin
        // drop unknown request types, no answer
      end
    endcase
  endfunction

  always @(posedge clk) begin
    energy_answer_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SPINS; i++) begin
        for (int j = 0; j < NUM_SPINS; j++) begin
          coupling_w[i][j] = '0;
        end
        field_w[i]   = '0;
        spin_down[i] = 1'b0;
      end
      offset_q8 = '0;
      energy_answers_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) begin
        offset_q8 = cfg_wr_data;
      end
      // check the answer before the request of this edge can add one
      if (rsp.valid && rsp.ready) begin
        if (energy_answers_q.size() == 0) begin
          $error("energy answer with none expected: energy_value %0d, is_total %0d",
                 rsp.energy_value, rsp.is_total);
          mismatch_count++;
        end else begin
          want = energy_answers_q.pop_front();
          if (rsp.energy_value !== want.energy) begin
            $error("energy_value: expected %0d, got %0d", want.energy, rsp.energy_value);
            mismatch_count++;
          end
          if (rsp.is_total !== want.is_total) begin
            $error("is_total: expected %0d, got %0d", want.is_total, rsp.is_total);
            mismatch_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        apply_request(req.req_type, req.spin_a, req.spin_b, req.weight_value);
      end
      outstanding <= energy_answers_q.size();
    end
  end

endmodule

// ----- verif/ising_energy_engine_tb.sv -----
// ----------------------------------------------------------------------------
// ising_energy_engine_tb
// Drives the Ising energy engine with a directed set of writes, flips and
// queries, then random phases under several energy offsets with random gaps
// on both handshakes and one long response stall. Checking lives in the
// checker instance beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ising_energy_engine_tb;
  import iee_pkg::*;

  localparam int                     STALL_LIMIT   = 20000;
  localparam int                     PHASE_ITEMS   = 290;
  localparam int                     SQUEEZE_LEN   = 2500;
  localparam logic [TYPE_W-1:0]      REQ_NONE_LO   = TYPE_W'(5);
  localparam logic [TYPE_W-1:0]      REQ_NONE_HI   = TYPE_W'(7);
  localparam logic signed [IN_W-1:0] W_MAX         = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] W_MIN         = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic [CFG_W-1:0]       OFFSET_MAX    = {1'b0, {(CFG_W-1){1'b1}}};
  localparam logic [CFG_W-1:0]       OFFSET_MIN    = {1'b1, {(CFG_W-1){1'b0}}};
  localparam logic [IDX_W-1:0]       SPIN_LAST     = IDX_W'(NUM_SPINS - 1);

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  int               mismatch_count;
  int               outstanding;
  int               quiet_cycles = 0;
  bit               squeeze_rsp;

  iee_req_if req_ch ();
  iee_rsp_if rsp_ch ();

  ising_energy_engine dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  iee_energy_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #5 clk = ~clk;

  // Most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(90, 20);
  endfunction

  // Bias toward a few hot spins so entries build up and saturate
  function automatic logic [IDX_W-1:0] pick_spin();
    if ($urandom_range(3) == 0) return IDX_W'($urandom_range(7));
    return IDX_W'($urandom_range(NUM_SPINS - 1));
  endfunction

  function automatic logic signed [IN_W-1:0] pick_weight();
    int r;
    r = $urandom_range(9);
    if (r < 4) return IN_W'($urandom());
    if (r < 8) return IN_W'($urandom_range(511)) - IN_W'(256);
    return $urandom_range(1) ? W_MAX : W_MIN;
  endfunction

  task automatic issue_request(
    input logic [TYPE_W-1:0]      kind,
    input logic [IDX_W-1:0]       a,
    input logic [IDX_W-1:0]       b,
    input logic signed [IN_W-1:0] w
  );
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.spin_a       <= a;
    req_ch.spin_b       <= b;
    req_ch.weight_value <= w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic issue_random_request(output bit counted);
    int               r;
    logic [TYPE_W-1:0] kind;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    r = $urandom_range(99);
    if (r < 34) begin
      kind = REQ_ADD_CPL;
    end else if (r < 50) begin
      kind = REQ_ADD_FIELD;
    end else if (r < 68) begin
      kind = REQ_FLIP;
    end else if (r < 90) begin
      kind = REQ_QUERY_DELTA;
    end else if (r < 95) begin
      kind = REQ_QUERY_TOTAL;
    end else begin
      kind = TYPE_W'($urandom_range(int'(REQ_NONE_HI), int'(REQ_NONE_LO)));
    end
    a = pick_spin();
    b = ($urandom_range(7) == 0) ? a : pick_spin();
    issue_request(kind, a, b, pick_weight());
    counted = (kind <= REQ_QUERY_TOTAL);
  endtask

  // Wait until every answer is back, then let a trailing write finish
  task automatic drain_answers();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_offset(input logic [CFG_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Response side: random holds, one long hold-off once asked
  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_rsp) begin
        squeeze_rsp = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      n = ($urandom_range(9) == 0) ? 150 : $urandom_range(30, 1);
      repeat (n) @(posedge clk);
    end
  end

  // Count cycles in which neither channel moves a request or an answer
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_offset [5];
    bit               counted;
    int               done;
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    squeeze_rsp         = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_ADD_CPL;
    req_ch.spin_a       = '0;
    req_ch.spin_b       = '0;
    req_ch.weight_value = '0;
    phase_offset[0] = OFFSET_MAX;
    phase_offset[1] = OFFSET_MIN;
    phase_offset[2] = '0;
    phase_offset[3] = $urandom();
    phase_offset[4] = $urandom();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_offset($urandom());

    // Directed: reset state, far corners, self coupling, saturation both ways
    issue_request(REQ_QUERY_TOTAL, '0, '0, '0);
    issue_request(REQ_QUERY_DELTA, SPIN_LAST, '0, '0);
    issue_request(REQ_ADD_CPL, '0, SPIN_LAST, W_MAX);
    issue_request(REQ_ADD_CPL, SPIN_LAST, '0, W_MAX);
    issue_request(REQ_ADD_CPL, IDX_W'(5), IDX_W'(5), W_MAX);
    issue_request(REQ_ADD_CPL, IDX_W'(5), IDX_W'(5), W_MAX);
    issue_request(REQ_ADD_CPL, IDX_W'(5), SPIN_LAST, W_MIN);
    issue_request(REQ_ADD_CPL, IDX_W'(5), SPIN_LAST, W_MIN);
    issue_request(REQ_ADD_FIELD, SPIN_LAST, '0, W_MIN);
    issue_request(REQ_ADD_FIELD, SPIN_LAST, '0, W_MIN);
    issue_request(REQ_ADD_FIELD, '0, '0, W_MAX);
    issue_request(REQ_QUERY_DELTA, '0, '0, '0);
    issue_request(REQ_QUERY_DELTA, IDX_W'(5), '0, '0);
    issue_request(REQ_FLIP, '0, '0, '0);
    issue_request(REQ_FLIP, SPIN_LAST, '1, W_MIN);
    issue_request(REQ_QUERY_DELTA, SPIN_LAST, '0, '0);
    issue_request(REQ_QUERY_TOTAL, '1, '1, '1);
    issue_request(REQ_NONE_LO, IDX_W'(3), IDX_W'(4), W_MAX);
    issue_request(REQ_NONE_LO + TYPE_W'(1), '1, '1, '1);
    issue_request(REQ_NONE_HI, IDX_W'(1), IDX_W'(2), W_MIN);
    issue_request(REQ_ADD_CPL, IDX_W'(1), IDX_W'(2), -IN_W'(1));
    issue_request(REQ_FLIP, IDX_W'(1), '0, '0);
    issue_request(REQ_QUERY_DELTA, IDX_W'(2), '0, '0);
    issue_request(REQ_FLIP, '0, '0, '0);
    issue_request(REQ_QUERY_TOTAL, '0, '0, '0);

    for (int phase = 0; phase < 5; phase++) begin
      drain_answers();
      write_offset(phase_offset[phase]);
      if (phase == 1) begin
        squeeze_rsp = 1'b1;
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
        issue_random_request(counted);
        if (counted) done++;
      end
    end

    drain_answers();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
